// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL modules.
// ----------------------------------------------------------------------------
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sdsd_pkg.sv =====
// ----------------------------------------------------------------------------
// sdsd_pkg
// Shared types and constants of the signed decimal seven-segment driver.
// ----------------------------------------------------------------------------
`default_nettype none

package sdsd_pkg;

  localparam int unsigned VALUE_BITS = 52;
  localparam int unsigned SEG_BITS   = 8;
  localparam int unsigned SEL_BITS   = 8;

  localparam logic [SEG_BITS-1:0] SEG_MINUS  = 8'hbf;
  localparam logic [SEG_BITS-1:0] SEG_BLANK  = 8'hff;
  localparam logic [SEG_BITS-1:0] SEG_DP_CLR = 8'h7f;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // take a new input value
    logic convert;  // one binary-to-BCD shift step
    logic trim;     // drop one leading zero digit
    logic emit;     // produce one digit beat
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic trim_done;  // no further leading zero to drop
    logic out_free;   // output register can take a beat this cycle
    logic last_item;  // next beat is the rightmost position
  } sts_t;

  // Active-low segment pattern of one decimal digit.
  function automatic logic [SEG_BITS-1:0] seg_of_digit(input logic [3:0] d);
    logic [SEG_BITS-1:0] s;
    unique case (d)
      4'd0:    s = 8'hc0;
      4'd1:    s = 8'hf9;
      4'd2:    s = 8'ha4;
      4'd3:    s = 8'hb0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hf8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sdsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdsd_ctrl
// Sequencer: conversion, leading-zero trim and digit output phases.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sdsd_ctrl #(
  parameter int unsigned FRACTION_BITS = 24
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  input  sdsd_pkg::sts_t   sts_i,
  output sdsd_pkg::cmd_t   cmd_o,
  output logic             busy_o
);

  localparam int unsigned IntBits = sdsd_pkg::VALUE_BITS - FRACTION_BITS;
  localparam int unsigned CntBits = $clog2(IntBits);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_TRIM,
    ST_EMIT
  } state_e;

  state_e             state_q, state_d;
  logic [CntBits-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CntBits'(IntBits - 1);
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.convert = 1'b1;
        cnt_d         = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if (sts_i.trim_done) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.trim = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_item) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  `SDSD_ASSERT_SAME(a_emit_needs_room, cmd_o.emit, sts_i.out_free, "emit without output room")
  `SDSD_ASSERT_NEXT(a_last_ends_value, cmd_o.emit && sts_i.last_item, !busy_o,
                    "sequencer still busy after the last beat")

endmodule

`default_nettype wire

// ===== rtl/sdsd_datapath.sv =====
// ----------------------------------------------------------------------------
// sdsd_datapath
// Magnitude, serial binary-to-BCD conversion, fraction digits, output beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sdsd_datapath #(
  parameter int unsigned DIGIT_COUNT   = 8,
  parameter int unsigned FRACTION_BITS = 24
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  sdsd_pkg::cmd_t                        cmd_i,
  output sdsd_pkg::sts_t                        sts_o,
  input  wire signed [sdsd_pkg::VALUE_BITS-1:0] value_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [sdsd_pkg::SEG_BITS-1:0]         segments_o,
  output logic [sdsd_pkg::SEL_BITS-1:0]         digit_select_o,
  output logic                                  last_o
);

  localparam int unsigned VBits    = sdsd_pkg::VALUE_BITS;
  localparam int unsigned IntBits  = VBits - FRACTION_BITS;
  localparam int unsigned BcdDigs  = (IntBits * 31) / 100 + 1;
  localparam int unsigned BcdBits  = 4 * BcdDigs;
  localparam int unsigned LeftBits = $clog2(BcdDigs + 1);
  localparam int unsigned ItemBits = $clog2(DIGIT_COUNT);
  localparam int unsigned SelBase  = sdsd_pkg::SEL_BITS - DIGIT_COUNT;

  logic                      sign_q;
  logic [IntBits-1:0]        ip_q;
  logic [BcdBits-1:0]        bcd_q;
  logic [LeftBits-1:0]       left_q;
  logic [FRACTION_BITS-1:0]  frac_q;
  logic [ItemBits-1:0]       item_q;

  logic                      out_valid_q;
  logic [sdsd_pkg::SEG_BITS-1:0] seg_q, seg_d;
  logic [sdsd_pkg::SEL_BITS-1:0] sel_q;
  logic                      last_q;

  logic [VBits-1:0]          mag;
  logic [BcdBits-1:0]        bcd_adj;
  logic [FRACTION_BITS+3:0]  frac_x10;
  logic [3:0]                top_dig;
  logic                      item_last;

  // Magnitude of the two's complement input; exact also for the most negative.
  assign mag = value_i[VBits-1] ? (~value_i + 1'b1) : value_i;

  // Add-3 correction of every BCD digit before a shift.
  always_comb begin
    for (int i = 0; i < int'(BcdDigs); i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
                                                     : bcd_q[4*i +: 4];
    end
  end

  assign frac_x10  = ({4'b0, frac_q} << 3) + ({4'b0, frac_q} << 1);
  assign top_dig   = bcd_q[BcdBits-1 -: 4];
  assign item_last = (item_q == ItemBits'(DIGIT_COUNT - 1));

  // Segment pattern of the next beat: sign, integer digit, or fraction digit.
  always_comb begin
    if (sign_q) begin
      seg_d = sdsd_pkg::SEG_MINUS;
    end else if (left_q != '0) begin
      seg_d = sdsd_pkg::seg_of_digit(top_dig);
      if (left_q == LeftBits'(1)) begin
        seg_d = seg_d & sdsd_pkg::SEG_DP_CLR;
      end
    end else begin
      seg_d = sdsd_pkg::seg_of_digit(frac_x10[FRACTION_BITS+3 -: 4]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sign_q <= value_i[VBits-1];
      ip_q   <= mag[VBits-1:FRACTION_BITS];
      frac_q <= mag[FRACTION_BITS-1:0];
      bcd_q  <= '0;
      left_q <= LeftBits'(BcdDigs);
      item_q <= '0;
    end else if (cmd_i.convert) begin
      bcd_q <= {bcd_adj[BcdBits-2:0], ip_q[IntBits-1]};
      ip_q  <= {ip_q[IntBits-2:0], 1'b0};
    end else if (cmd_i.trim) begin
      bcd_q  <= {bcd_q[BcdBits-5:0], 4'b0};
      left_q <= left_q - 1'b1;
    end else if (cmd_i.emit) begin
      item_q <= item_q + 1'b1;
      if (sign_q) begin
        sign_q <= 1'b0;
      end else if (left_q != '0) begin
        bcd_q  <= {bcd_q[BcdBits-5:0], 4'b0};
        left_q <= left_q - 1'b1;
      end else begin
        frac_q <= frac_x10[FRACTION_BITS-1:0];
      end
    end
  end

  // Output register; a waiting beat does not hold up conversion of the next value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      seg_q  <= seg_d;
      sel_q  <= sdsd_pkg::SEL_BITS'(1) << (SelBase + int'(item_q));
      last_q <= item_last;
    end
  end

  assign sts_o.trim_done = (top_dig != 4'd0) || (left_q <= LeftBits'(1));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.last_item = item_last;

  assign out_valid_o    = out_valid_q;
  assign segments_o     = seg_q;
  assign digit_select_o = sel_q;
  assign last_o         = last_q;

  `SDSD_ASSERT_SAME(a_trim_keeps_digit, cmd_i.trim, left_q > LeftBits'(1),
                    "trim would remove the units digit")
  `SDSD_ASSERT_SAME(a_bcd_digit_range, cmd_i.trim || cmd_i.emit, top_dig <= 4'd9,
                    "BCD digit out of range")
  `SDSD_ASSERT_NEXT(a_last_flag, cmd_i.emit && item_last, last_o && out_valid_o,
                    "rightmost beat not flagged as last")

endmodule

`default_nettype wire

// ===== rtl/signed_decimal_seven_segment_driver.sv =====
// ----------------------------------------------------------------------------
// signed_decimal_seven_segment_driver
// Turns a signed fixed-point value into a run of seven-segment digit beats.
// ----------------------------------------------------------------------------
// Each accepted value produces exactly DIGIT_COUNT output beats, leftmost
// position first. A beat carries an active-low segment byte (bit 7 is the
// decimal point) and a one-hot digit select, and last marks the rightmost
// position. Negative values start with a minus sign, integer digits follow
// without leading zeros (a zero integer part shows as 0), the units digit
// carries the decimal point, and the remaining positions show truncated
// fraction digits. Digits that do not fit are dropped. The block works on one
// value at a time: the integer part is converted to BCD by a shift-and-add-3
// loop over the integer bits, then leading zero digits are dropped at one per
// cycle (at most the BCD digit count less one) until the sequencer sees that
// no further zero is left, and then the beats go out at one per cycle while
// the output side does not stall. The input stall is low only while the block
// is idle; the final beat of a value may still wait in the output register
// while the next value is being accepted and converted.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_decimal_seven_segment_driver #(
  parameter int unsigned DIGIT_COUNT   = 8,
  parameter int unsigned FRACTION_BITS = 24
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // Input channel: one signed fixed-point value per beat.
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire signed [sdsd_pkg::VALUE_BITS-1:0] value_i,
  // Output channel: one digit per beat.
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [sdsd_pkg::SEG_BITS-1:0]         segments_o,
  output logic [sdsd_pkg::SEL_BITS-1:0]         digit_select_o,
  output logic                                  last_o
);

  sdsd_pkg::cmd_t cmd;
  sdsd_pkg::sts_t sts;
  logic           busy;

  // The sequencer only moves on to a new value from its idle state, so the
  // input stall is simply the busy indication.
  sdsd_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  // Datapath holds the value being shown, the BCD register and the output beat.
  sdsd_datapath #(
    .DIGIT_COUNT   (DIGIT_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .segments_o     (segments_o),
    .digit_select_o (digit_select_o),
    .last_o         (last_o)
  );

  assign in_stall_o = busy;

endmodule

`default_nettype wire

// ===== tb/sv/tb_signed_decimal_seven_segment_driver.sv =====
// ----------------------------------------------------------------------------
// tb_signed_decimal_seven_segment_driver
// Self-checking bench for the signed decimal seven-segment driver.
// ----------------------------------------------------------------------------
// A short table of hand-picked values goes in first: zero, the extremes of the
// input range, the most negative and most positive raw words, tiny negative
// values, values with too many integer digits and values whose integer part
// lies above the stated range. A stream of random values follows. Every
// accepted value is expanded into its eight expected digit beats, and every
// digit beat that leaves the block is compared field by field with the oldest
// expectation. The sender works in bursts and the receiver stalls in changing
// modes, so gaps and back-pressure land on every phase of the conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_signed_decimal_seven_segment_driver;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_BITS   = sdsd_pkg::VALUE_BITS;
  localparam int unsigned SEG_BITS     = sdsd_pkg::SEG_BITS;
  localparam int unsigned SEL_BITS     = sdsd_pkg::SEL_BITS;

  localparam int unsigned DIGITS       = 8;
  localparam int unsigned FRAC_BITS    = 24;
  localparam int unsigned INT_BITS     = VALUE_BITS - FRAC_BITS;
  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RANDOM_ITEMS = 98;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned IDLE_LIMIT   = 2000;

  // Active-low patterns of the decimal digits 0 to 9.
  localparam logic [SEG_BITS-1:0] DIGIT_SEGS [10] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
  };

  // One digit beat as it appears on the output channel.
  typedef struct packed {
    logic [SEG_BITS-1:0] segments;
    logic [SEL_BITS-1:0] digit_select;
    logic                last;
  } digit_beat_t;

  // One row of the directed table. The segment bytes of all eight positions
  // are packed leftmost first; they are only used when typed is set, and the
  // predictor fills them in otherwise.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  typed;
    logic [8*DIGITS-1:0]   segs;
  } display_row_t;

  localparam int unsigned ROW_COUNT = 22;
  localparam display_row_t DISPLAY_ROWS [ROW_COUNT] = '{
    // Zero shows a single 0 with the point, then zero fraction digits.
    '{52'h0,             1'b1, 64'h40c0c0c0c0c0c0c0},
    // One exactly.
    '{52'h1000000,       1'b1, 64'h79c0c0c0c0c0c0c0},
    // One half and minus one half.
    '{52'h0800000,       1'b1, 64'h4092c0c0c0c0c0c0},
    '{52'hfffffff800000, 1'b1, 64'hbf4092c0c0c0c0c0},
    // Top of the stated range: eight integer nines, point on the last one.
    '{52'd1677721599999999, 1'b1, 64'h9090909090909010},
    // Bottom of the stated range: the minus sign pushes the point out.
    '{-52'd1677721599999999, 1'b1, 64'hbf90909090909090},
    // Most negative raw word: its magnitude is still taken exactly.
    '{52'h8000000000000, 1'b1, 64'hbff9b099a4f9f8f8},
    // Most positive raw word: integer above the range, leading digits only.
    '{52'h7ffffffffffff, 1'b1, 64'hf9b099a4f9f8f8a4},
    // Smallest negative magnitude: the sign still shows.
    '{52'hfffffffffffff, 1'b1, 64'hbf40c0c0c0c0c0c0},
    // The rest is checked against the predictor.
    '{52'h1,             1'b0, 64'h0},
    '{52'hffffff,        1'b0, 64'h0},
    '{52'h3243f6a,       1'b0, 64'h0},
    '{52'h19999a,        1'b0, 64'h0},
    '{(52'd12345678 << 24) | 52'h800000,    1'b0, 64'h0},
    '{-((52'd1234567 << 24) | 52'hc00000),  1'b0, 64'h0},
    '{-((52'd9 << 24) | 52'hffbe77),        1'b0, 64'h0},
    '{52'd10 << 24,                         1'b0, 64'h0},
    '{-(52'd10 << 24),                      1'b0, 64'h0},
    '{52'd123456789 << 24,                  1'b0, 64'h0},
    '{52'd100000000 << 24,                  1'b0, 64'h0},
    '{-(52'd99999999 << 24),                1'b0, 64'h0},
    '{-(52'd134217727 << 24),               1'b0, 64'h0}
  };

  // Output back-pressure modes, each held for a random stretch of cycles.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_LONG
  } stall_mode_e;

  // Every input of the block starts at a known value.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic [VALUE_BITS-1:0] value_i     = '0;
  logic                  out_stall_i = 1'b0;

  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [SEG_BITS-1:0]   segments_o;
  logic [SEL_BITS-1:0]   digit_select_o;
  logic                  last_o;

  // Digit beats still owed by the block, oldest first.
  digit_beat_t expected_beats [$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;

  stall_mode_e stall_mode = STALL_NONE;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  logic        hold_level = 1'b0;

  signed_decimal_seven_segment_driver #(
    .DIGIT_COUNT   (DIGITS),
    .FRACTION_BITS (FRAC_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .segments_o     (segments_o),
    .digit_select_o (digit_select_o),
    .last_o         (last_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Predictor: the segment bytes of all eight positions for one raw value,
  // leftmost position in the top byte. The magnitude is taken on the full
  // word width, so the most negative word keeps its exact magnitude. Positions
  // past the rightmost one are simply not written.
  function automatic logic [8*DIGITS-1:0] display_pattern(
    input logic [VALUE_BITS-1:0] raw
  );
    logic [8*DIGITS-1:0]   segs;
    logic [VALUE_BITS-1:0] mag;
    logic [INT_BITS-1:0]   whole;
    logic [FRAC_BITS-1:0]  frac;
    logic [FRAC_BITS+3:0]  scaled;
    logic [3:0]            decimals [10];
    int unsigned           cnt;
    int unsigned           pos;
    segs = '0;
    pos = 0;
    mag = raw[VALUE_BITS-1] ? -raw : raw;
    whole = mag[VALUE_BITS-1:FRAC_BITS];
    frac = mag[FRAC_BITS-1:0];
    if (raw[VALUE_BITS-1]) begin
      segs[8*DIGITS-1-8*pos -: 8] = sdsd_pkg::SEG_MINUS;
      pos++;
    end
    // Integer digits, least significant first; zero still yields one digit.
    cnt = 0;
    do begin
      decimals[cnt] = 4'(whole % 10);
      whole = whole / 10;
      cnt++;
    end while (whole != 0);
    for (int i = int'(cnt) - 1; i >= 1; i--) begin
      if (pos < DIGITS) begin
        segs[8*DIGITS-1-8*pos -: 8] = DIGIT_SEGS[decimals[i]];
        pos++;
      end
    end
    // The units digit carries the decimal point.
    if (pos < DIGITS) begin
      segs[8*DIGITS-1-8*pos -: 8] = DIGIT_SEGS[decimals[0]] & sdsd_pkg::SEG_DP_CLR;
      pos++;
    end
    // Fraction digits: times ten, the carry out of the fraction is the digit.
    while (pos < DIGITS) begin
      scaled = {4'b0, frac} * 28'd10;
      segs[8*DIGITS-1-8*pos -: 8] = DIGIT_SEGS[scaled[FRAC_BITS+3:FRAC_BITS]];
      frac = scaled[FRAC_BITS-1:0];
      pos++;
    end
    return segs;
  endfunction

  // Turns eight segment bytes into the digit beats the block owes. The select
  // is one-hot from the leftmost position upward, and last marks the rightmost one.
  task automatic queue_display(input logic [8*DIGITS-1:0] segs);
    digit_beat_t beat;
    for (int k = 0; k < DIGITS; k++) begin
      beat.segments     = segs[8*DIGITS-1-8*k -: 8];
      beat.digit_select = SEL_BITS'(1) << k;
      beat.last         = (k == DIGITS - 1);
      expected_beats.push_back(beat);
    end
  endtask

  // Random values favor well-formed numbers: a magnitude class for the
  // integer part, a random fraction (sometimes exactly zero) and a random
  // sign. A tenth of them are raw words, which reach every bit pattern.
  function automatic logic [VALUE_BITS-1:0] random_value();
    logic [VALUE_BITS-1:0] v;
    logic [INT_BITS-1:0]   whole;
    logic [FRAC_BITS-1:0]  frac;
    frac = FRAC_BITS'($urandom());
    if ($urandom_range(0, 7) == 0) frac = '0;
    case ($urandom_range(0, 5))
      0:       whole = '0;
      1:       whole = INT_BITS'($urandom_range(1, 9));
      2:       whole = INT_BITS'($urandom_range(10, 9999));
      3:       whole = INT_BITS'($urandom_range(10000, 99999999));
      4:       whole = INT_BITS'($urandom());
      default: whole = INT_BITS'($urandom_range(0, 999));
    endcase
    v = {whole, frac};
    if ($urandom_range(0, 1) == 1) v = -v;
    if ($urandom_range(0, 9) == 0) v = VALUE_BITS'({$urandom(), $urandom()});
    return v;
  endfunction

  // Sends one value. A new burst may open with a gap of idle cycles; within
  // a burst valid stays high from one beat to the next. The expected digit
  // beats are queued at the edge where the value is accepted.
  task automatic send_value(input logic [VALUE_BITS-1:0] v,
                            input logic [8*DIGITS-1:0] segs);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    queue_display(segs);
  endtask

  // Stimulus and end of run.
  initial begin
    logic [VALUE_BITS-1:0] v;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: typed rows carry their own expected segments.
    for (int r = 0; r < ROW_COUNT; r++) begin
      send_value(DISPLAY_ROWS[r].value,
                 DISPLAY_ROWS[r].typed ? DISPLAY_ROWS[r].segs
                                       : display_pattern(DISPLAY_ROWS[r].value));
    end

    // Random values, all checked against the predictor.
    repeat (RANDOM_ITEMS) begin
      v = random_value();
      send_value(v, display_pattern(v));
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Wait for every owed beat, then a little longer to catch stray beats.
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** signed_decimal_seven_segment_driver: PASSED **");
    end else begin
      $display("** signed_decimal_seven_segment_driver: FAILED **");
    end
    $finish;
  end

  // Output back-pressure. The mode changes after each random stretch: no stall,
  // a light random stall, a heavy random stall, or long alternating runs of
  // stall and release.
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 120);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE: begin
        out_stall_i <= 1'b0;
      end
      STALL_LIGHT: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      STALL_HEAVY: begin
        out_stall_i <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (hold_left == 0) begin
          hold_left  = $urandom_range(1, 20);
          hold_level = ~hold_level;
        end
        hold_left--;
        out_stall_i <= hold_level;
      end
    endcase
  end

  // Checks each accepted digit beat against the oldest expectation.
  always @(posedge clk_i) begin
    digit_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected digit beat: segments %h, digit_select %h, last %b",
               segments_o, digit_select_o, last_o);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        if (segments_o !== want.segments) begin
          $error("segments: expected %h, got %h", want.segments, segments_o);
          mismatches++;
        end
        if (digit_select_o !== want.digit_select) begin
          $error("digit_select: expected %h, got %h", want.digit_select, digit_select_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %b, got %b", want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves a beat for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** signed_decimal_seven_segment_driver: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/sdsd_pkg.sv
rtl/sdsd_ctrl.sv
rtl/sdsd_datapath.sv
rtl/signed_decimal_seven_segment_driver.sv
tb/sv/tb_signed_decimal_seven_segment_driver.sv
